// ----- rtl/lvol_pkg.sv -----
package lvol_pkg;

  localparam int unsigned MaxBeamsDefault = 1024;

  localparam logic [15:0] SafeReset  = 16'd1280;
  localparam logic [15:0] TolReset   = 16'd128;
  localparam logic [15:0] StartReset = 16'd0;
  localparam logic [15:0] StepReset  = 16'd182;
  localparam logic [15:0] LowerReset = 16'd0;
  localparam logic [15:0] UpperReset = 16'd65535;

  localparam logic [2:0] RegSafe  = 3'd0;
  localparam logic [2:0] RegTol   = 3'd1;
  localparam logic [2:0] RegStart = 3'd2;
  localparam logic [2:0] RegStep  = 3'd3;
  localparam logic [2:0] RegLower = 3'd4;
  localparam logic [2:0] RegUpper = 3'd5;

  // arctan table, 2^24 per turn
  function automatic logic signed [24:0] atan_lut(input logic [3:0] i);
    case (i)
      4'd0:    atan_lut = 25'sd2097152;
      4'd1:    atan_lut = 25'sd1238021;
      4'd2:    atan_lut = 25'sd654136;
      4'd3:    atan_lut = 25'sd332050;
      4'd4:    atan_lut = 25'sd166669;
      4'd5:    atan_lut = 25'sd83416;
      4'd6:    atan_lut = 25'sd41718;
      4'd7:    atan_lut = 25'sd20860;
      4'd8:    atan_lut = 25'sd10430;
      4'd9:    atan_lut = 25'sd5215;
      4'd10:   atan_lut = 25'sd2608;
      4'd11:   atan_lut = 25'sd1304;
      4'd12:   atan_lut = 25'sd652;
      4'd13:   atan_lut = 25'sd326;
      4'd14:   atan_lut = 25'sd163;
      default: atan_lut = 25'sd81;
    endcase
  endfunction

endpackage

// ----- rtl/lidar_velocity_obstacle_limiter_core.sv -----
// one range sample per input word. the first word of a scan (tuser set) loads the
// reference velocity and heading, the word with tlast set leaves the limited velocity
// in the output register. a word is taken in the idle state; it then goes through the
// beam offset (bit-serial multiply of beam index by angle step), one cordic setup step
// and 16 iterations, the projection and correction steps on one shared 18x36
// multiplier, and one update step; only after that is a new word taken. a finished result
// waits in the output register while the next word is already worked on; only when a
// second result is ready before the first has left does the update step stall.
// a sample outside (range_lower, range_upper) still goes through the same steps but
// leaves the velocity unlimited; it advances the beam counter.
module lidar_velocity_obstacle_limiter_core #(
  parameter int unsigned MAX_BEAMS = lvol_pkg::MaxBeamsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // ref_vx, ref_vy, heading, range_sample
  input  logic        s_tuser,   // scan_start
  input  logic        s_tlast,   // scan_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // out_vx, out_vy
  output logic        m_tuser,   // stopped
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = (MAX_BEAMS > 1) ? $clog2(MAX_BEAMS) : 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_OFFS = 6'b000010,
    S_CORD = 6'b000100,
    S_PROJ = 6'b001000,
    S_CORR = 6'b010000,
    S_UPD  = 6'b100000
  } state_t;

  state_t state;
  logic [15:0] safe, tol, astart, astep, lower, upper;
  logic signed [15:0] vel_x, vel_y;
  logic [15:0] yaw_held;
  logic [IW-1:0] beam_index;
  logic stop_flag;

  logic [15:0] r;
  logic end_f, valid_f;
  logic [3:0] cnt;
  logic [15:0] off, step_sh;
  logic [IW-1:0] idx_sh;
  logic signed [17:0] cx, cy;
  logic signed [24:0] cz;
  logic flip;
  logic flip_done;
  logic [IW-1:0] idx_now;
  logic signed [17:0] cc, ss;
  logic [16:0] mrg;
  logic signed [35:0] prod_a;
  logic signed [37:0] p;
  logic signed [39:0] d;
  logic [1:0] sub;

  assign pready = 1'b1;
  wire wr = psel & penable & pwrite;
  wire [2:0] ra = paddr[4:2];

  always_comb begin
    case (ra)
      lvol_pkg::RegSafe:  prdata = {16'd0, safe};
      lvol_pkg::RegTol:   prdata = {16'd0, tol};
      lvol_pkg::RegStart: prdata = {16'd0, astart};
      lvol_pkg::RegStep:  prdata = {16'd0, astep};
      lvol_pkg::RegLower: prdata = {16'd0, lower};
      lvol_pkg::RegUpper: prdata = {16'd0, upper};
      default:            prdata = 32'd0;
    endcase
  end

  wire acc = s_tvalid & s_tready;
  assign s_tready = (state == S_IDLE);
  wire [15:0] rin = s_tdata[63:48];
  wire start = s_tuser;

  // result goes out unless the previous one is still waiting
  wire out_load = (state == S_UPD) && end_f && (!m_tvalid || m_tready);
  wire upd_stall = (state == S_UPD) && end_f && m_tvalid && !m_tready;

  // shared multiplier
  logic signed [17:0] mul_a;
  logic signed [35:0] mul_b;
  logic signed [53:0] mul_y;
  assign mul_y = mul_a * mul_b;

  logic signed [17:0] cx_sh, cy_sh;
  assign cx_sh = cx >>> cnt;
  assign cy_sh = cy >>> cnt;

  logic [15:0] theta;
  assign theta = yaw_held - off;

  wire signed [53:0] rnd = mul_y + 54'sd134217728;
  wire signed [26:0] corr = 27'(rnd >>> 28);

  always_comb begin
    mul_a = cc;
    mul_b = 36'(vel_x);
    case (sub)
      2'd0: begin mul_a = cc; mul_b = 36'(vel_x); end
      2'd1: begin mul_a = ss; mul_b = 36'(vel_y); end
      2'd2: begin mul_a = cc; mul_b = d[35:0]; end
      default: begin mul_a = ss; mul_b = d[35:0]; end
    endcase
    if (state == S_PROJ && sub == 2'd2) begin
      mul_a = 18'(signed'({1'b0, tol}));
      mul_b = 36'(signed'({1'b0, mrg}));
    end else if (state == S_PROJ && sub == 2'd3) begin
      mul_a = cc;
      mul_b = 36'(vel_x);
    end
  end

  function automatic logic signed [15:0] sat(input logic signed [27:0] v);
    if (v > 28'sd32767) sat = 16'sh7fff;
    else if (v < -28'sd32768) sat = -16'sh8000;
    else sat = v[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      safe <= lvol_pkg::SafeReset; tol <= lvol_pkg::TolReset;
      astart <= lvol_pkg::StartReset; astep <= lvol_pkg::StepReset;
      lower <= lvol_pkg::LowerReset; upper <= lvol_pkg::UpperReset;
      vel_x <= '0; vel_y <= '0; yaw_held <= '0; beam_index <= '0; stop_flag <= 1'b0;
      flip_done <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (wr) begin
        case (ra)
          lvol_pkg::RegSafe:  safe   <= pwdata[15:0];
          lvol_pkg::RegTol:   tol    <= pwdata[15:0];
          lvol_pkg::RegStart: astart <= pwdata[15:0];
          lvol_pkg::RegStep:  astep  <= pwdata[15:0];
          lvol_pkg::RegLower: lower  <= pwdata[15:0];
          lvol_pkg::RegUpper: upper  <= pwdata[15:0];
          default: ;
        endcase
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tdata <= stop_flag ? 32'd0 : {vel_y, vel_x};
        m_tuser <= stop_flag;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: if (acc) begin
          if (start) begin
            vel_x <= s_tdata[15:0]; vel_y <= s_tdata[31:16];
            yaw_held <= s_tdata[47:32]; stop_flag <= 1'b0;
          end
          idx_sh <= start ? '0 : beam_index;
          r <= rin; end_f <= s_tlast;
          valid_f <= (rin > lower) && (rin < upper);
          off <= astart; step_sh <= astep; cnt <= '0;
          state <= S_OFFS;
        end
        S_OFFS: begin
          // bit-serial index times step
          if (idx_sh[0]) off <= off + step_sh;
          idx_sh <= idx_sh >> 1;
          step_sh <= step_sh << 1;
          cnt <= cnt + 4'd1;
          if (32'(cnt) == IW - 1 || cnt == 4'd15) begin
            cnt <= '0;
            state <= S_CORD;
            mrg <= (r >= safe) ? 17'(r - safe) : 17'(safe - r);
          end
        end
        S_CORD: begin
          if (cnt == 4'd0 && !flip_done) begin
            flip <= (16'(theta + 16'd16384)) >= 16'd32768;
            cz <= 25'(signed'(theta + ((16'(theta + 16'd16384) >= 16'd32768) ?
                  16'd32768 : 16'd0))) * 25'sd256;
            cx <= 18'sd9949; cy <= '0;
            flip_done <= 1'b1;
          end else begin
            if (cz >= 0) begin
              cx <= cx - cy_sh; cy <= cy + cx_sh; cz <= cz - lvol_pkg::atan_lut(cnt);
            end else begin
              cx <= cx + cy_sh; cy <= cy - cx_sh; cz <= cz + lvol_pkg::atan_lut(cnt);
            end
            cnt <= cnt + 4'd1;
            if (cnt == 4'd15) begin
              state <= S_PROJ; sub <= 2'd0; flip_done <= 1'b0;
            end
          end
        end
        S_PROJ: begin
          if (sub == 2'd0) begin
            cc <= flip ? -cx : cx; ss <= flip ? -cy : cy;
            sub <= 2'd3;
          end else if (sub == 2'd3) begin
            prod_a <= 36'(mul_y); sub <= 2'd1;
          end else if (sub == 2'd1) begin
            p <= 38'(prod_a) + 38'(mul_y); sub <= 2'd2;
          end else begin
            d <= 40'(p) - 40'(signed'({1'b0, mul_y[32:0], 6'd0}));
            state <= S_CORR; sub <= 2'd2;
          end
        end
        S_CORR: begin
          if (sub == 2'd2) begin
            prod_a <= 36'(corr); sub <= 2'd3;
          end else begin
            state <= S_UPD;
            if (valid_f) begin
              if (mrg == 17'd0) begin
                if (p > 0) stop_flag <= 1'b1;
              end else if (!d[39]) begin
                vel_x <= sat(28'(vel_x) - 28'(prod_a));
                vel_y <= sat(28'(vel_y) - 28'(corr));
              end
            end
          end
        end
        S_UPD: begin
          if (!upd_stall) begin
            beam_index <= (32'(idx_now) + 1 >= MAX_BEAMS) ? '0 : idx_now + 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) if (acc) idx_now <= start ? '0 : beam_index;

  a_out_only_on_end: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_UPD) && $past(end_f)) else $error("bad emit");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_tready) else $error("accept while busy");
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 32'd0) else $error("stopped not zero");

endmodule

// ----- tb/lvol_checker.sv -----
module lvol_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,   // ref_vx, ref_vy, heading, range_sample
  input  logic        s_tuser,   // scan_start
  input  logic        s_tlast,   // scan_end
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // out_vx, out_vy
  input  logic        m_tuser,   // stopped
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fails,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BeamCount = int'(lvol_pkg::MaxBeamsDefault);
  localparam int ArcTab [16] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
    20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic               stopped;
  } limit_t;

  limit_t limit_q[$];

  logic [15:0] safe_rng, tol, ang_start, ang_step, rng_lo, rng_hi;
  int          vel_x, vel_y;
  logic [15:0] yaw;
  int          beam;
  logic        stop_flag;

  function automatic int clamp16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  // cos/sin in Q1.14, left half plane handled by a half-turn flip
  function automatic void beam_dir(input logic [15:0] ang, output int c, output int s);
    logic [15:0] q, a;
    logic        flip;
    int          x, y, z, dx, dy;
    q = ang + 16'd16384;
    flip = q[15];
    a = flip ? ang + 16'd32768 : ang;
    z = int'($signed(a)) * 256;
    x = 9949;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - ArcTab[i];
      end else begin
        x = x + dx; y = y - dy; z = z + ArcTab[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  task automatic limit_beam(input logic [63:0] d, input logic first, input logic last);
    logic [15:0] r, off, theta, m;
    int          c, s;
    longint      p, t, dd, cx, cy;
    limit_t      res;
    r = d[63:48];
    if (first) begin
      vel_x = int'($signed(d[15:0]));
      vel_y = int'($signed(d[31:16]));
      yaw = d[47:32];
      beam = 0;
      stop_flag = 1'b0;
    end
    if (r > rng_lo && r < rng_hi) begin
      off = ang_start + 16'(beam * int'(ang_step));
      theta = yaw - off;
      m = (r >= safe_rng) ? r - safe_rng : safe_rng - r;
      beam_dir(theta, c, s);
      p = longint'(vel_x) * c + longint'(vel_y) * s;
      t = longint'(tol) * longint'(m) * 64;
      if (m == 0) begin
        if (p > 0) stop_flag = 1'b1;
      end else if (p >= t) begin
        dd = p - t;
        cx = (longint'(c) * dd + (longint'(1) <<< 27)) >>> 28;
        cy = (longint'(s) * dd + (longint'(1) <<< 27)) >>> 28;
        vel_x = clamp16(longint'(vel_x) - cx);
        vel_y = clamp16(longint'(vel_y) - cy);
      end
    end
    beam = (beam + 1 >= BeamCount) ? 0 : beam + 1;
    if (last) begin
      res.vx = stop_flag ? 16'sd0 : 16'(vel_x);
      res.vy = stop_flag ? 16'sd0 : 16'(vel_y);
      res.stopped = stop_flag;
      limit_q = {limit_q, res};
    end
  endtask

  always @(posedge clk) begin
    limit_t want;
    if (rst) begin
      safe_rng = lvol_pkg::SafeReset; tol = lvol_pkg::TolReset;
      ang_start = lvol_pkg::StartReset; ang_step = lvol_pkg::StepReset;
      rng_lo = lvol_pkg::LowerReset; rng_hi = lvol_pkg::UpperReset;
      vel_x = 0; vel_y = 0; yaw = '0; beam = 0; stop_flag = 1'b0;
      limit_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (3'(paddr >> 2))
          lvol_pkg::RegSafe:  safe_rng = pwdata[15:0];
          lvol_pkg::RegTol:   tol = pwdata[15:0];
          lvol_pkg::RegStart: ang_start = pwdata[15:0];
          lvol_pkg::RegStep:  ang_step = pwdata[15:0];
          lvol_pkg::RegLower: rng_lo = pwdata[15:0];
          lvol_pkg::RegUpper: rng_hi = pwdata[15:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) limit_beam(s_tdata, s_tuser, s_tlast);
      if (m_tvalid && m_tready) begin
        if (limit_q.size() == 0) begin
          $display("%0t: unexpected word vx=%0d vy=%0d stopped=%0b", $time,
                   $signed(m_tdata[15:0]), $signed(m_tdata[31:16]), m_tuser);
          fails++;
        end else begin
          want = limit_q.pop_front();
          if (m_tdata[15:0] !== want.vx) begin
            $display("%0t: out_vx expected %0d actual %0d", $time, want.vx,
                     $signed(m_tdata[15:0]));
            fails++;
          end
          if (m_tdata[31:16] !== want.vy) begin
            $display("%0t: out_vy expected %0d actual %0d", $time, want.vy,
                     $signed(m_tdata[31:16]));
            fails++;
          end
          if (m_tuser !== want.stopped) begin
            $display("%0t: stopped expected %0b actual %0b", $time, want.stopped, m_tuser);
            fails++;
          end
        end
      end
    end
    pending = limit_q.size();
  end

endmodule

// ----- tb/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] RegSpare = 3'd6;
  localparam logic [2:0] RegSpareTop = 3'd7;

  logic        clk, rst;
  logic        s_tvalid, s_tready;
  logic [63:0] s_tdata;   // ref_vx, ref_vy, heading, range_sample
  logic        s_tuser;   // scan_start
  logic        s_tlast;   // scan_end
  logic        m_tvalid, m_tready;
  logic [31:0] m_tdata;   // out_vx, out_vy
  logic        m_tuser;   // stopped
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          fails, pending;
  int          sent;
  int          burst;
  logic [15:0] safe_now;

  lidar_velocity_obstacle_limiter_core uut (.*);

  lvol_checker chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast, .m_tvalid,
    .m_tready, .m_tdata, .m_tuser, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fails, .pending
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  // receiver: alternating ready/random stretches, one long hold-off
  initial begin
    int cyc, hold;
    bit held;
    m_tready = 1'b0;
    cyc = 0;
    hold = 0;
    held = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (!held && sent >= 300) begin
        held = 1;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if ((cyc / 64) % 3 == 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'($urandom_range(0, 1));
      end
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [15:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= {16'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    int n;
    s_tvalid <= 1'b0;
    n = 0;
    while (pending != 0 && n < 400000) begin
      @(posedge clk);
      n++;
    end
    repeat (60) @(posedge clk);
  endtask

  task automatic set_limits(input logic [15:0] sd, tl, st, sp, lo, hi);
    reg_write(lvol_pkg::RegSafe, sd);
    reg_write(lvol_pkg::RegTol, tl);
    reg_write(lvol_pkg::RegStart, st);
    reg_write(lvol_pkg::RegStep, sp);
    reg_write(lvol_pkg::RegLower, lo);
    reg_write(lvol_pkg::RegUpper, hi);
    safe_now = sd;
  endtask

  // offer one word and wait for it to be taken; random gap afterwards unless in a burst
  task automatic send_beam(input bit first, input bit last, input logic [15:0] vx, vy,
                           input logic [15:0] hd, input logic [15:0] r);
    s_tvalid <= 1'b1;
    s_tdata <= {r, hd, vy, vx};
    s_tuser <= first;
    s_tlast <= last;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    sent++;
    if (burst > 0) begin
      burst--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      burst = $urandom_range(0, 20);
    end
  endtask

  function automatic logic [15:0] pick_range();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return safe_now;
      3: return 16'($urandom);
      default: return safe_now + 16'($urandom_range(0, 1024)) - 16'd512;
    endcase
  endfunction

  task automatic random_scan(input int len);
    logic [15:0] vx, vy;
    if ($urandom_range(0, 2) == 0) begin
      vx = 16'($urandom);
      vy = 16'($urandom);
    end else begin
      vx = 16'($urandom_range(0, 2048)) - 16'd1024;
      vy = 16'($urandom_range(0, 2048)) - 16'd1024;
    end
    for (int i = 0; i < len; i++)
      send_beam(i == 0, i == len - 1, vx, vy, 16'($urandom), pick_range());
  endtask

  task automatic random_phase(input int items);
    int goal;
    goal = sent + items;
    while (sent < goal) begin
      case ($urandom_range(0, 9))
        // stray words and broken scans
        0: send_beam(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 16'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom));
        1: send_beam(1'b0, 1'b1, 16'($urandom), 16'($urandom), 16'($urandom),
                     pick_range());
        default: random_scan($urandom_range(1, 30));
      endcase
    end
  endtask

  initial begin
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0; s_tlast = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    sent = 0;
    burst = 0;
    safe_now = lvol_pkg::SafeReset;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: before any scan start, extremes, zero margin, one-beam scans
    send_beam(1'b0, 1'b1, 16'h7fff, 16'h8000, 16'hffff, 16'd2000);
    send_beam(1'b1, 1'b0, 16'h7fff, 16'h8000, 16'h0000, 16'h0000);
    send_beam(1'b0, 1'b0, 16'h0, 16'h0, 16'h0, 16'hffff);
    send_beam(1'b0, 1'b0, 16'h0, 16'h0, 16'h0, 16'd1300);
    send_beam(1'b0, 1'b1, 16'h0, 16'h0, 16'h0, 16'd1200);
    send_beam(1'b1, 1'b1, 16'h0400, 16'h0000, 16'h0000, 16'd1280);
    send_beam(1'b1, 1'b1, 16'hfc00, 16'h0000, 16'h0000, 16'd1280);
    send_beam(1'b1, 1'b0, 16'h0400, 16'h0000, 16'h0000, 16'd1280);
    send_beam(1'b0, 1'b1, 16'h0400, 16'h0000, 16'h0000, 16'd1000);
    send_beam(1'b1, 1'b1, 16'h8000, 16'h8000, 16'h4000, 16'd1);
    send_beam(1'b1, 1'b1, 16'h7fff, 16'h7fff, 16'hc000, 16'd1);
    send_beam(1'b1, 1'b1, 16'h7fff, 16'h0000, 16'h8000, 16'd600);
    send_beam(1'b1, 1'b1, 16'h0000, 16'h7fff, 16'h4000, 16'd600);
    send_beam(1'b1, 1'b1, 16'hffff, 16'hffff, 16'hffff, 16'hfffe);
    settle();

    set_limits(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h0000, 16'hffff);
    reg_write(RegSpare, 16'h1234);
    reg_write(RegSpareTop, 16'h5678);
    send_beam(1'b1, 1'b1, 16'h7fff, 16'h7fff, 16'h0000, 16'hfffe);
    send_beam(1'b1, 1'b1, 16'h7fff, 16'h8000, 16'h1234, 16'h0001);
    random_phase(200);
    settle();

    set_limits(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffff);
    send_beam(1'b1, 1'b1, 16'h0100, 16'h0100, 16'h2000, 16'h0000);
    random_phase(200);
    settle();

    // a scan long enough to wrap the beam counter
    set_limits(16'd1280, 16'd64, 16'd100, 16'd64, 16'd256, 16'd8000);
    random_scan(1030);
    settle();

    for (int ph = 0; ph < 3; ph++) begin
      set_limits(16'($urandom_range(0, 8000)), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom_range(0, 600)),
                 16'($urandom_range(3000, 65535)));
      random_phase(130);
      settle();
    end

    set_limits(lvol_pkg::SafeReset, lvol_pkg::TolReset, lvol_pkg::StartReset,
               lvol_pkg::StepReset, lvol_pkg::LowerReset, lvol_pkg::UpperReset);
    random_phase(100);
    settle();

    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
